// ----- rtl/hprp_pkg.sv -----
// hprp_pkg: shared types, codes and constants for the heap profile record parser.
// No dependencies; imported by every module of the block.
package hprp_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [3:0]  VARINT_LIMIT = 4'd10;
  localparam logic [60:0] TOP_STRINGS  = 61'd6;
  localparam logic [60:0] TOP_FUNCTION = 61'd5;
  localparam logic [60:0] TOP_LOCATION = 61'd4;
  localparam logic [60:0] TOP_SAMPLE   = 61'd2;
  localparam logic [60:0] ITEM_ID      = 61'd1;
  localparam logic [60:0] FUNC_NAME    = 61'd2;
  localparam logic [60:0] LOC_LINE     = 61'd4;
  localparam logic [60:0] LINE_FUNC    = 61'd1;
  localparam logic [60:0] SAMPLE_LOC   = 61'd1;
  localparam logic [60:0] SAMPLE_VAL   = 61'd2;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIX64  = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_FIX32  = 3'd5;

  typedef enum logic [2:0] {
    LV_TAG, LV_LEN, LV_SKIPVAR, LV_BYTES, LV_MSG, LV_LINE, LV_PLOC, LV_PVAL
  } nest_t;

  typedef enum logic [2:0] {
    K_SKIP, K_STRING, K_FUNC, K_LOC, K_SAMPLE
  } outer_t;

  typedef enum logic [3:0] {
    ST_TAG, ST_ID, ST_A, ST_LOC, ST_VAL, ST_VSKIP,
    ST_LLINE, ST_LPLOC, ST_LPVAL, ST_LSKIP, ST_BYTES
  } step_t;

  typedef enum logic [1:0] {
    KIND_FUNC, KIND_LOC, KIND_SAMPLE, KIND_END
  } kind_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [63:0]        key;
    logic signed [63:0] val_a;
    logic signed [63:0] val_b;
    logic               has_loc;
    logic               status;
    logic               endm;
  } rec_t;

  typedef struct packed {
    nest_t                   nest;
    outer_t                  outer;
    logic [2:0]              ifw;
    step_t                   step;
    logic [LENGTH_BITS-1:0]  msg_left;
    logic [LENGTH_BITS-1:0]  sub_left;
    logic [63:0]             skip_left;
    logic [63:0]             acc;
    logic [3:0]              vbytes;
    logic [63:0]             rid;
    logic [63:0]             va;
    logic [63:0]             vb;
    logic [2:0]              vpos;
    logic                    line_seen;
    logic                    loc_seen;
    logic [31:0]             strings;
    logic                    err;
    logic                    stopped;
  } parse_st_t;

  // front -> queue
  typedef struct packed {
    logic [1:0] n;
    rec_t       r0;
    rec_t       r1;
  } push_t;

  // queue -> front/back
  typedef struct packed {
    logic              room;
    logic              nonempty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

// ----- rtl/hprp_ifs.sv -----
// hprp_ifs: valid/ready channel interfaces for the byte input and record output.
// Depends on nothing.
interface hprp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;
  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface hprp_rec_if;
  logic               valid;
  logic               ready;
  logic [1:0]         record_kind;
  logic [63:0]        record_key;
  logic signed [63:0] first_value;
  logic signed [63:0] second_value;
  logic               has_location;
  logic               parse_status;
  logic               end_marker;
  modport source (output valid, record_kind, record_key, first_value, second_value,
                  has_location, parse_status, end_marker, input ready);
  modport sink   (input valid, record_kind, record_key, first_value, second_value,
                  has_location, parse_status, end_marker, output ready);
endinterface

// ----- rtl/hprp_front.sv -----
// hprp_front: byte-wide protobuf wire-format walker; emits up to two records per byte.
// Depends on hprp_pkg.
module hprp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  input  logic [7:0]       data_byte,
  input  logic             final_byte,
  input  hprp_pkg::q_stat_t q_stat,
  output logic             ready,
  output hprp_pkg::push_t  push
);
  import hprp_pkg::*;

  parse_st_t st, st_next;
  logic      accept;
  rec_t      rec_a, rec_end;
  logic      got_a;

  function automatic void add_byte(inout parse_st_t s, input logic [7:0] b);
    if (s.vbytes < VARINT_LIMIT) begin
      s.acc    = s.acc | (64'(b[6:0]) << (7 * s.vbytes));
      s.vbytes = s.vbytes + 4'd1;
    end
  endfunction

  function automatic void apply_value(inout parse_st_t s, input logic [63:0] v);
    case (s.step)
      ST_ID: s.rid = v;
      ST_A:  s.va  = v;
      ST_LOC: begin
        if (!s.loc_seen) begin
          s.rid      = v;
          s.loc_seen = 1'b1;
        end
      end
      ST_VAL: begin
        if (s.vpos == 3'd2) s.va = v;
        if (s.vpos == 3'd3) s.vb = v;
        if (s.vpos < 3'd4) s.vpos = s.vpos + 3'd1;
      end
      default: ;
    endcase
  endfunction

  function automatic step_t skip_step(inout parse_st_t s, input logic [2:0] w);
    step_t r;
    r = ST_TAG;
    if (w == WT_VARINT) r = ST_VSKIP;
    else if (w == WT_FIX64) begin
      s.skip_left = 64'd8;
      r = ST_BYTES;
    end else if (w == WT_LEN) r = ST_LSKIP;
    else if (w == WT_FIX32) begin
      s.skip_left = 64'd4;
      r = ST_BYTES;
    end
    return r;
  endfunction

  function automatic void decode_inner_tag(inout parse_st_t s, input logic [63:0] tag);
    logic [60:0] field;
    logic [2:0]  w;
    field = tag[63:3];
    w     = tag[2:0];
    s.ifw = w;
    if (s.nest == LV_LINE) begin
      if (field == LINE_FUNC) s.step = ST_A;
      else s.step = skip_step(s, w);
    end else if (s.outer == K_FUNC) begin
      if (field == ITEM_ID) s.step = ST_ID;
      else if (field == FUNC_NAME) s.step = ST_A;
      else s.step = skip_step(s, w);
    end else if (s.outer == K_LOC) begin
      if (field == ITEM_ID) s.step = ST_ID;
      else if (field == LOC_LINE && !s.line_seen) s.step = ST_LLINE;
      else s.step = skip_step(s, w);
    end else begin
      if (field == SAMPLE_LOC) s.step = (w == WT_LEN) ? ST_LPLOC : ST_LOC;
      else if (field == SAMPLE_VAL) s.step = (w == WT_LEN) ? ST_LPVAL : ST_VAL;
      else s.step = skip_step(s, w);
    end
  endfunction

  function automatic void handle_len(inout parse_st_t s, input logic [63:0] v);
    logic [LENGTH_BITS-1:0] r;
    logic [LENGTH_BITS-1:0] n;
    step_t                  stp;
    r   = (s.nest >= LV_LINE) ? s.sub_left : s.msg_left;
    n   = (v < 64'(r)) ? LENGTH_BITS'(v) : r;
    stp = s.step;
    s.step = ST_TAG;
    if (stp == ST_LLINE) begin
      s.line_seen = 1'b1;
      if (n != '0) begin
        s.nest     = LV_LINE;
        s.sub_left = n;
      end
    end else if (stp == ST_LPLOC || stp == ST_LPVAL) begin
      if (n != '0) begin
        s.nest     = (stp == ST_LPLOC) ? LV_PLOC : LV_PVAL;
        s.sub_left = n;
        s.step     = (stp == ST_LPLOC) ? ST_LOC : ST_VAL;
      end
    end else if (n != '0) begin
      s.skip_left = 64'(n);
      s.step      = ST_BYTES;
    end
  endfunction

  // Region end: finish a cut-short tag or value.
  function automatic void settle(inout parse_st_t s);
    logic [63:0] v;
    logic        go;
    v  = s.acc;
    go = 1'b1;
    if (s.nest == LV_PLOC || s.nest == LV_PVAL) begin
      if (s.vbytes != 4'd0) apply_value(s, v);
    end else begin
      if (s.step == ST_TAG) begin
        if (s.vbytes == 4'd0) go = 1'b0;
        else begin
          decode_inner_tag(s, v);
          v = 64'd0;
        end
      end
      if (go) begin
        if (s.step >= ST_ID && s.step <= ST_VSKIP) apply_value(s, v);
        else if (s.step == ST_LLINE) s.line_seen = 1'b1;
      end
    end
    s.acc    = 64'd0;
    s.vbytes = 4'd0;
    s.step   = ST_TAG;
  endfunction

  function automatic rec_t emit(input parse_st_t s);
    rec_t r;
    r       = '0;
    r.key   = s.rid;
    r.val_a = s.va;
    if (s.outer == K_FUNC) r.kind = KIND_FUNC;
    else if (s.outer == K_LOC) r.kind = KIND_LOC;
    else begin
      r.kind    = KIND_SAMPLE;
      r.val_b   = s.vb;
      r.has_loc = s.loc_seen;
    end
    return r;
  endfunction

  function automatic void inner_byte(inout parse_st_t s, input logic [7:0] b,
                                     inout rec_t rec, inout logic got);
    logic [63:0] v;
    s.msg_left = s.msg_left - LENGTH_BITS'(1);
    if (s.nest >= LV_LINE) s.sub_left = s.sub_left - LENGTH_BITS'(1);
    if (s.step == ST_BYTES) begin
      s.skip_left = s.skip_left - 64'd1;
      if (s.skip_left == 64'd0) s.step = ST_TAG;
    end else begin
      add_byte(s, b);
      if (!b[7] || s.vbytes >= VARINT_LIMIT) begin
        v        = s.acc;
        s.acc    = 64'd0;
        s.vbytes = 4'd0;
        if (s.step == ST_TAG) decode_inner_tag(s, v);
        else if (s.step >= ST_LLINE) handle_len(s, v);
        else begin
          apply_value(s, v);
          if (s.nest == LV_MSG || s.nest == LV_LINE) s.step = ST_TAG;
        end
      end
    end
    if (s.nest >= LV_LINE && s.sub_left == '0) begin
      settle(s);
      s.nest = LV_MSG;
    end
    if (s.msg_left == '0) begin
      settle(s);
      rec    = emit(s);
      got    = 1'b1;
      s.nest = LV_TAG;
    end
  endfunction

  function automatic void count_string(inout parse_st_t s);
    if (s.strings != 32'hFFFF_FFFF) s.strings = s.strings + 32'd1;
  endfunction

  function automatic void top_tag(inout parse_st_t s, input logic [63:0] tag);
    logic [60:0] field;
    logic [2:0]  w;
    field  = tag[63:3];
    w      = tag[2:0];
    s.nest = LV_LEN;
    if (field == TOP_STRINGS) s.outer = K_STRING;
    else if (field == TOP_FUNCTION) s.outer = K_FUNC;
    else if (field == TOP_LOCATION) s.outer = K_LOC;
    else if (field == TOP_SAMPLE) s.outer = K_SAMPLE;
    else begin
      s.outer = K_SKIP;
      if (w == WT_VARINT) s.nest = LV_SKIPVAR;
      else if (w == WT_FIX64 || w == WT_FIX32) begin
        s.skip_left = (w == WT_FIX64) ? 64'd8 : 64'd4;
        s.nest      = LV_BYTES;
      end else if (w != WT_LEN) s.err = 1'b1;
    end
  endfunction

  function automatic void top_len(inout parse_st_t s, input logic [63:0] v,
                                  inout rec_t rec, inout logic got);
    s.nest = LV_TAG;
    if (s.outer == K_SKIP || s.outer == K_STRING) begin
      if (v == 64'd0) begin
        if (s.outer == K_STRING) count_string(s);
      end else begin
        s.skip_left = v;
        s.nest      = LV_BYTES;
      end
    end else if ((v >> LENGTH_BITS) != 64'd0) begin
      s.err = 1'b1;
    end else begin
      s.rid       = 64'd0;
      s.va        = 64'd0;
      s.vb        = 64'd0;
      s.vpos      = 3'd0;
      s.line_seen = 1'b0;
      s.loc_seen  = 1'b0;
      s.step      = ST_TAG;
      s.ifw       = 3'd0;
      if (v == 64'd0) begin
        rec = emit(s);
        got = 1'b1;
      end else begin
        s.msg_left = v[LENGTH_BITS-1:0];
        s.nest     = LV_MSG;
      end
    end
  endfunction

  function automatic void top_byte(inout parse_st_t s, input logic [7:0] b,
                                   inout rec_t rec, inout logic got);
    logic [63:0] v;
    if (s.nest == LV_BYTES) begin
      s.skip_left = s.skip_left - 64'd1;
      if (s.skip_left == 64'd0) begin
        if (s.outer == K_STRING) count_string(s);
        s.nest = LV_TAG;
      end
    end else begin
      add_byte(s, b);
      if (b[7]) begin
        if (s.vbytes >= VARINT_LIMIT) s.err = 1'b1;
      end else begin
        v        = s.acc;
        s.acc    = 64'd0;
        s.vbytes = 4'd0;
        if (s.nest == LV_TAG) top_tag(s, v);
        else if (s.nest == LV_LEN) top_len(s, v, rec, got);
        else s.nest = LV_TAG;
      end
    end
  endfunction

  assign ready  = q_stat.room;
  assign accept = valid && ready;

  always_comb begin
    parse_st_t s;
    s       = st;
    rec_a   = '0;
    got_a   = 1'b0;
    rec_end = '0;
    push    = '0;
    if (!s.stopped) begin
      if (!s.err) begin
        if (s.nest >= LV_MSG) inner_byte(s, data_byte, rec_a, got_a);
        else top_byte(s, data_byte, rec_a, got_a);
      end
      if (final_byte) begin
        if (!s.err && s.nest != LV_TAG) s.err = 1'b1;
        rec_end.kind   = KIND_END;
        rec_end.key    = 64'(s.strings);
        rec_end.status = s.err;
        rec_end.endm   = 1'b1;
        s.stopped      = 1'b1;
      end
    end
    st_next = s;
    if (accept && !st.stopped) begin
      if (got_a) begin
        push.r0 = rec_a;
        push.r1 = rec_end;
        push.n  = final_byte ? 2'd2 : 2'd1;
      end else if (final_byte) begin
        push.r0 = rec_end;
        push.n  = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule

// ----- rtl/hprp_queue.sv -----
// hprp_queue: short record queue between parser front and output stage.
// Takes up to two records per cycle, gives one. Depends on hprp_pkg.
module hprp_queue (
  input  logic              clk,
  input  logic              rst,
  input  hprp_pkg::push_t   push,
  input  logic              pop,
  output hprp_pkg::rec_t    head,
  output hprp_pkg::q_stat_t q_stat
);
  import hprp_pkg::*;

  rec_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head            = mem[rd_ptr];
  assign q_stat.count    = count;
  assign q_stat.nonempty = (count != '0);
  assign q_stat.room     = (count <= QCNT_W'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr_ptr] <= push.r0;
    if (push.n == 2'd2) mem[wr_ptr + QPTR_W'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.n);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push.n) - QCNT_W'(pop);
    end
  end

endmodule

// ----- rtl/hprp_back.sv -----
// hprp_back: output register stage; drains the record queue onto the result channel.
// Depends on hprp_pkg.
module hprp_back (
  input  logic              clk,
  input  logic              rst,
  input  hprp_pkg::rec_t    head,
  input  hprp_pkg::q_stat_t q_stat,
  input  logic              out_ready,
  output logic              pop,
  output logic              out_valid,
  output hprp_pkg::rec_t    out_rec
);
  import hprp_pkg::*;

  assign pop = q_stat.nonempty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_rec <= head;
  end

endmodule

// ----- rtl/heap_profile_record_parser_core.sv -----
// heap_profile_record_parser_core: top level of the heap profile record parser.
// Depends on hprp_pkg, hprp_ifs, hprp_front, hprp_queue, hprp_back.
//
//  channel   dir  transaction       payload
//  byte_in   in   one stream byte   data_byte[7:0], final_byte
//  rec_out   out  one record        record_kind, record_key, first_value,
//                                   second_value, has_location, parse_status,
//                                   end_marker
//
// One byte per cycle while byte_in.ready is high: the front walks the wire
// format as each byte is accepted and may produce up to two records (message
// record plus end). Records pass a 4-entry queue to a registered output.
// byte_in.ready drops only while fewer than two queue slots are free.
// Reset (rst, synchronous) puts the parser at top level awaiting a tag.
// After the end record all further bytes are taken and dropped until reset.
module heap_profile_record_parser_core (
  input logic         clk,
  input logic         rst,
  hprp_byte_if.sink   byte_in,
  hprp_rec_if.source  rec_out
);
  import hprp_pkg::*;

  push_t   push;
  q_stat_t q_stat;
  rec_t    head;
  rec_t    out_rec;
  logic    pop;

  // Front: parse and classify each byte.
  hprp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .valid      (byte_in.valid),
    .data_byte  (byte_in.data_byte),
    .final_byte (byte_in.final_byte),
    .q_stat     (q_stat),
    .ready      (byte_in.ready),
    .push       (push)
  );

  // Queue decouples the parser from result backpressure.
  hprp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  // Back: output register.
  hprp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .out_ready (rec_out.ready),
    .pop       (pop),
    .out_valid (rec_out.valid),
    .out_rec   (out_rec)
  );

  assign rec_out.record_kind  = out_rec.kind;
  assign rec_out.record_key   = out_rec.key;
  assign rec_out.first_value  = out_rec.val_a;
  assign rec_out.second_value = out_rec.val_b;
  assign rec_out.has_location = out_rec.has_loc;
  assign rec_out.parse_status = out_rec.status;
  assign rec_out.end_marker   = out_rec.endm;

  // Queue never holds more than its depth.
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("record queue overflow");

  // End marker only rides on end-of-stream records.
  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    rec_out.valid && rec_out.end_marker |-> rec_out.record_kind == KIND_END)
    else $error("end marker on non-end record");

  // Nothing follows the end record.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    rec_out.valid && rec_out.ready && rec_out.end_marker |=> !rec_out.valid)
    else $error("record after end of stream");

endmodule

// ----- tb/hprp_record_checker.sv -----
// hprp_record_checker: watches the byte and record channels of the parser,
// predicts records from accepted bytes and compares them. Uses hprp_pkg, hprp_ifs.
`timescale 1ns / 1ps
module hprp_record_checker (
  input  logic  clk,
  input  logic  rst,
  hprp_byte_if  bi,
  hprp_rec_if   ro,
  output int    fails,
  output int    pending
);
  import hprp_pkg::*;

  nest_t       lvl;
  outer_t      outer;
  logic [2:0]  ifw;
  step_t       step;
  logic [63:0] msg_left, sub_left, skip_left, acc, rid, va, vb;
  logic [3:0]  vbytes;
  logic [2:0]  vpos;
  bit          line_seen, loc_seen, err, stopped;
  logic [31:0] strings;
  rec_t        want_q[$];

  assign pending = want_q.size();

  function automatic logic [63:0] len_max();
    return LENGTH_BITS >= 64 ? '1 : (64'd1 << LENGTH_BITS) - 64'd1;
  endfunction

  function automatic void clear_model();
    lvl = LV_TAG; outer = K_SKIP; ifw = '0; step = ST_TAG;
    msg_left = '0; sub_left = '0; skip_left = '0; acc = '0; vbytes = '0;
    rid = '0; va = '0; vb = '0; vpos = '0;
    line_seen = 0; loc_seen = 0; err = 0; stopped = 0; strings = '0;
    want_q.delete();
  endfunction

  function automatic void queue_rec(kind_t k, logic [63:0] key, logic [63:0] a,
                                    logic [63:0] b, logic has, logic st, logic e);
    rec_t r;
    r.kind = k; r.key = key; r.val_a = a; r.val_b = b;
    r.has_loc = has; r.status = st; r.endm = e;
    want_q.push_back(r);
  endfunction

  function automatic void close_message();
    case (outer)
      K_FUNC:  queue_rec(KIND_FUNC, rid, va, '0, 1'b0, 1'b0, 1'b0);
      K_LOC:   queue_rec(KIND_LOC, rid, va, '0, 1'b0, 1'b0, 1'b0);
      default: queue_rec(KIND_SAMPLE, rid, va, vb, loc_seen, 1'b0, 1'b0);
    endcase
  endfunction

  function automatic void take7(logic [7:0] b);
    if (vbytes < VARINT_LIMIT) begin
      acc = acc | (64'(b[6:0]) << (7 * vbytes));
      vbytes = vbytes + 4'd1;
    end
  endfunction

  function automatic void store_value(logic [63:0] v);
    case (step)
      ST_ID: rid = v;
      ST_A:  va = v;
      ST_LOC: begin
        if (!loc_seen) begin
          rid = v;
          loc_seen = 1;
        end
      end
      ST_VAL: begin
        if (vpos == 3'd2) va = v;
        if (vpos == 3'd3) vb = v;
        if (vpos < 3'd4) vpos = vpos + 3'd1;
      end
      default: ;
    endcase
  endfunction

  function automatic step_t skip_for(logic [2:0] wt);
    if (wt == WT_VARINT) return ST_VSKIP;
    if (wt == WT_FIX64) begin skip_left = 64'd8; return ST_BYTES; end
    if (wt == WT_LEN) return ST_LSKIP;
    if (wt == WT_FIX32) begin skip_left = 64'd4; return ST_BYTES; end
    return ST_TAG;
  endfunction

  function automatic void inner_tag(logic [63:0] t);
    logic [60:0] fld;
    logic [2:0]  wt;
    fld = t[63:3];
    wt = t[2:0];
    ifw = wt;
    if (lvl == LV_LINE) begin
      step = (fld == LINE_FUNC) ? ST_A : skip_for(wt);
    end else if (outer == K_FUNC) begin
      if (fld == ITEM_ID) step = ST_ID;
      else if (fld == FUNC_NAME) step = ST_A;
      else step = skip_for(wt);
    end else if (outer == K_LOC) begin
      if (fld == ITEM_ID) step = ST_ID;
      else if (fld == LOC_LINE && !line_seen) step = ST_LLINE;
      else step = skip_for(wt);
    end else begin
      if (fld == SAMPLE_LOC) step = (wt == WT_LEN) ? ST_LPLOC : ST_LOC;
      else if (fld == SAMPLE_VAL) step = (wt == WT_LEN) ? ST_LPVAL : ST_VAL;
      else step = skip_for(wt);
    end
  endfunction

  function automatic void inner_len(logic [63:0] v);
    logic [63:0] room, n;
    step_t s;
    room = (lvl >= LV_LINE) ? sub_left : msg_left;
    n = (v < room) ? v : room;
    s = step;
    step = ST_TAG;
    if (s == ST_LLINE) begin
      line_seen = 1;
      if (n != 0) begin lvl = LV_LINE; sub_left = n; end
    end else if (s == ST_LPLOC || s == ST_LPVAL) begin
      if (n != 0) begin
        lvl = (s == ST_LPLOC) ? LV_PLOC : LV_PVAL;
        sub_left = n;
        step = (s == ST_LPLOC) ? ST_LOC : ST_VAL;
      end
    end else if (n != 0) begin
      skip_left = n;
      step = ST_BYTES;
    end
  endfunction

  // A region ran out: finish the tag or value it cut short.
  function automatic void cut_short();
    logic [63:0] v;
    bit go;
    v = acc;
    go = 1;
    if (lvl == LV_PLOC || lvl == LV_PVAL) begin
      if (vbytes != 0) store_value(v);
    end else begin
      if (step == ST_TAG) begin
        if (vbytes == 0) go = 0;
        else begin inner_tag(v); v = '0; end
      end
      if (go) begin
        if (step >= ST_ID && step <= ST_VSKIP) store_value(v);
        else if (step == ST_LLINE) line_seen = 1;
      end
    end
    acc = '0; vbytes = '0;
    step = ST_TAG;
  endfunction

  function automatic void inner_byte(logic [7:0] b);
    logic [63:0] v;
    msg_left = msg_left - 64'd1;
    if (lvl >= LV_LINE) sub_left = sub_left - 64'd1;
    if (step == ST_BYTES) begin
      skip_left = skip_left - 64'd1;
      if (skip_left == 0) step = ST_TAG;
    end else begin
      take7(b);
      if (!b[7] || vbytes >= VARINT_LIMIT) begin
        v = acc;
        acc = '0; vbytes = '0;
        if (step == ST_TAG) inner_tag(v);
        else if (step >= ST_LLINE) inner_len(v);
        else begin
          store_value(v);
          if (lvl == LV_MSG || lvl == LV_LINE) step = ST_TAG;
        end
      end
    end
    if (lvl >= LV_LINE && sub_left == 0) begin
      cut_short();
      lvl = LV_MSG;
    end
    if (msg_left == 0) begin
      cut_short();
      close_message();
      lvl = LV_TAG;
    end
  endfunction

  function automatic void count_string();
    if (strings != 32'hFFFF_FFFF) strings = strings + 32'd1;
  endfunction

  function automatic void top_tag(logic [63:0] t);
    logic [60:0] fld;
    logic [2:0]  wt;
    fld = t[63:3];
    wt = t[2:0];
    lvl = LV_LEN;
    if (fld == TOP_STRINGS) outer = K_STRING;
    else if (fld == TOP_FUNCTION) outer = K_FUNC;
    else if (fld == TOP_LOCATION) outer = K_LOC;
    else if (fld == TOP_SAMPLE) outer = K_SAMPLE;
    else begin
      outer = K_SKIP;
      if (wt == WT_VARINT) lvl = LV_SKIPVAR;
      else if (wt == WT_FIX64) begin skip_left = 64'd8; lvl = LV_BYTES; end
      else if (wt == WT_FIX32) begin skip_left = 64'd4; lvl = LV_BYTES; end
      else if (wt != WT_LEN) err = 1;
    end
  endfunction

  function automatic void top_len(logic [63:0] v);
    lvl = LV_TAG;
    if (outer == K_SKIP || outer == K_STRING) begin
      if (v == 0) begin
        if (outer == K_STRING) count_string();
      end else begin
        skip_left = v;
        lvl = LV_BYTES;
      end
    end else if (v > len_max()) begin
      err = 1;
    end else begin
      rid = '0; va = '0; vb = '0; vpos = '0;
      line_seen = 0; loc_seen = 0; step = ST_TAG; ifw = '0;
      if (v == 0) close_message();
      else begin msg_left = v; lvl = LV_MSG; end
    end
  endfunction

  function automatic void top_byte(logic [7:0] b);
    logic [63:0] v;
    if (lvl == LV_BYTES) begin
      skip_left = skip_left - 64'd1;
      if (skip_left == 0) begin
        if (outer == K_STRING) count_string();
        lvl = LV_TAG;
      end
    end else begin
      take7(b);
      if (b[7]) begin
        if (vbytes >= VARINT_LIMIT) err = 1;
      end else begin
        v = acc;
        acc = '0; vbytes = '0;
        if (lvl == LV_TAG) top_tag(v);
        else if (lvl == LV_LEN) top_len(v);
        else lvl = LV_TAG;
      end
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic fin);
    if (!stopped) begin
      if (!err) begin
        if (lvl >= LV_MSG) inner_byte(b);
        else top_byte(b);
      end
      if (fin) begin
        if (!err && lvl != LV_TAG) err = 1;
        queue_rec(KIND_END, 64'(strings), '0, '0, 1'b0, err, 1'b1);
        stopped = 1;
      end
    end
  endfunction

  function automatic void flag(string what);
    fails++;
    if (fails <= 10) $display("%0t checker: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin
    rec_t w;
    if (rst) begin
      clear_model();
      fails = 0;
    end else begin
      if (bi.valid && bi.ready) parse_byte(bi.data_byte, bi.final_byte);
      if (ro.valid && ro.ready) begin
        if (want_q.size() == 0) begin
          flag($sformatf("unexpected record kind %0d key %h", ro.record_kind,
                         ro.record_key));
        end else begin
          w = want_q.pop_front();
          if (ro.record_kind !== w.kind || ro.record_key !== w.key ||
              ro.first_value !== w.val_a || ro.second_value !== w.val_b ||
              ro.has_location !== w.has_loc || ro.parse_status !== w.status ||
              ro.end_marker !== w.endm)
            flag($sformatf({"record mismatch exp kind %0d key %h a %h b %h has %b st %b ",
                            "end %b / got kind %0d key %h a %h b %h has %b st %b end %b"},
                           w.kind, w.key, w.val_a, w.val_b, w.has_loc, w.status, w.endm,
                           ro.record_kind, ro.record_key, ro.first_value,
                           ro.second_value, ro.has_location, ro.parse_status,
                           ro.end_marker));
        end
      end
    end
  end

endmodule

// ----- tb/tb.sv -----
// tb: stimulus and verdict for heap_profile_record_parser_core.
// Depends on hprp_pkg, hprp_ifs and hprp_record_checker.
`timescale 1ns / 1ps
module tb;
  import hprp_pkg::*;

  typedef logic [7:0] octet_t;

  localparam int IDLE_LIMIT = 4000; // cycles with no transaction at all
  localparam int STREAM_LEN = 1800;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails, pending;
  int   idle_cycles = 0;
  bit   calm = 0;         // no idling on either side while set
  octet_t stream_q[$];    // whole profile stream, final byte is the last one

  hprp_byte_if bytes_if();
  hprp_rec_if  recs_if();

  heap_profile_record_parser_core uut (
    .clk     (clk),
    .rst     (rst),
    .byte_in (bytes_if),
    .rec_out (recs_if)
  );

  hprp_record_checker chk (
    .clk     (clk),
    .rst     (rst),
    .bi      (bytes_if),
    .ro      (recs_if),
    .fails   (fails),
    .pending (pending)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------- encoding
  function automatic void put_varint(ref octet_t q[$], input logic [63:0] v);
    while (v >= 64'd128) begin
      q.push_back({1'b1, v[6:0]});
      v = v >> 7;
    end
    q.push_back(v[7:0]);
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(0, 127));
      3, 4, 5: return 64'($urandom_range(0, 16383));
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  // Inner value; now and then a ten-byte varint whose last byte may keep its
  // continuation bit, which the inner decoder must then cut off.
  function automatic void put_value(ref octet_t q[$]);
    if ($urandom_range(0, 19) == 0) begin
      repeat (9) q.push_back(8'h80 | 8'($urandom_range(0, 127)));
      q.push_back(8'($urandom_range(0, 255)));
    end else begin
      put_varint(q, pick_value());
    end
  endfunction

  function automatic void put_bytes(ref octet_t q[$], input int n);
    repeat (n) q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Length-delimited chunk; sometimes the length cuts the body short, which
  // leaves a partial tag or value at the region end.
  function automatic void put_wrapped(ref octet_t q[$], input logic [63:0] tag,
                                      input octet_t body[$], input bit may_cut);
    int n;
    n = body.size();
    if (may_cut && $urandom_range(0, 7) == 0) n = $urandom_range(0, n);
    put_varint(q, tag);
    put_varint(q, 64'(n));
    for (int i = 0; i < n; i++) q.push_back(body[i]);
  endfunction

  // Inner field the parser does not use, any wire type.
  function automatic void put_noise(ref octet_t q[$]);
    octet_t body[$];
    logic [2:0] wt;
    wt = 3'($urandom_range(0, 7));
    put_varint(q, {61'($urandom_range(6, 40)), wt});
    case (wt)
      WT_VARINT: put_value(q);
      WT_FIX64:  put_bytes(q, 8);
      WT_FIX32:  put_bytes(q, 4);
      WT_LEN: begin
        put_bytes(body, $urandom_range(0, 5));
        put_varint(q, 64'(body.size()));
        foreach (body[i]) q.push_back(body[i]);
      end
      default: ;  // groups and reserved types carry nothing inside
    endcase
  endfunction

  function automatic void put_list(ref octet_t q[$], input logic [63:0] tag);
    octet_t body[$];
    repeat ($urandom_range(0, 6)) put_value(body);
    put_wrapped(q, tag, body, 1);
  endfunction

  // Top-level tag of a message field, usually with wire type 2.
  function automatic logic [63:0] msg_tag(logic [60:0] fld);
    if ($urandom_range(0, 9) == 0) return {fld, 3'($urandom_range(0, 7))};
    return {fld, WT_LEN};
  endfunction

  function automatic void add_function(int parts);
    octet_t body[$];
    repeat (parts) begin
      case ($urandom_range(0, 3))
        0: begin put_varint(body, {ITEM_ID, WT_VARINT}); put_value(body); end
        1: begin put_varint(body, {FUNC_NAME, WT_VARINT}); put_value(body); end
        2: begin put_varint(body, 64'h10 | 64'($urandom_range(0, 7))); put_value(body); end
        default: put_noise(body);
      endcase
    end
    put_wrapped(stream_q, msg_tag(TOP_FUNCTION), body, 1);
  endfunction

  function automatic void add_location(int parts);
    octet_t body[$], line[$];
    repeat (parts) begin
      case ($urandom_range(0, 3))
        0: begin put_varint(body, {ITEM_ID, WT_VARINT}); put_value(body); end
        1, 2: begin
          line.delete();
          repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 2) != 0) begin
              put_varint(line, {LINE_FUNC, WT_VARINT});
              put_value(line);
            end else begin
              put_noise(line);
            end
          end
          put_wrapped(body, {LOC_LINE, WT_LEN}, line, 1);
        end
        default: put_noise(body);
      endcase
    end
    put_wrapped(stream_q, msg_tag(TOP_LOCATION), body, 1);
  endfunction

  function automatic void add_sample(int parts);
    octet_t body[$];
    repeat (parts) begin
      case ($urandom_range(0, 5))
        0: begin put_varint(body, {SAMPLE_LOC, WT_VARINT}); put_value(body); end
        1: put_list(body, {SAMPLE_LOC, WT_LEN});
        2: begin put_varint(body, {SAMPLE_VAL, WT_VARINT}); put_value(body); end
        3: put_list(body, {SAMPLE_VAL, WT_LEN});
        4: begin
          // wrong wire type on a known field still reads a varint
          put_varint(body, {61'($urandom_range(1, 2)), WT_FIX32});
          put_value(body);
        end
        default: put_noise(body);
      endcase
    end
    put_wrapped(stream_q, msg_tag(TOP_SAMPLE), body, 1);
  endfunction

  function automatic void add_string(int n);
    octet_t body[$];
    put_bytes(body, n);
    put_wrapped(stream_q, msg_tag(TOP_STRINGS), body, 0);
  endfunction

  // Skipped top-level field with a legal wire type.
  function automatic void add_other(logic [2:0] wt);
    logic [60:0] fld;
    octet_t body[$];
    do fld = 61'($urandom_range(1, 60));
    while (fld == TOP_STRINGS || fld == TOP_FUNCTION || fld == TOP_LOCATION ||
           fld == TOP_SAMPLE);
    if ($urandom_range(0, 15) == 0) fld = '1; // tag that needs a full ten bytes
    put_varint(stream_q, {fld, wt});
    case (wt)
      WT_VARINT: put_varint(stream_q, pick_value());
      WT_FIX64:  put_bytes(stream_q, 8);
      WT_FIX32:  put_bytes(stream_q, 4);
      default: begin
        put_bytes(body, $urandom_range(0, 6));
        put_varint(stream_q, 64'(body.size()));
        foreach (body[i]) stream_q.push_back(body[i]);
      end
    endcase
  endfunction

  function automatic void add_any();
    case ($urandom_range(0, 9))
      0, 1:    add_function($urandom_range(0, 5));
      2, 3:    add_location($urandom_range(0, 5));
      4, 5, 6: add_sample($urandom_range(0, 7));
      7:       add_string($urandom_range(0, 6));
      default: begin
        case ($urandom_range(0, 3))
          0: add_other(WT_VARINT);
          1: add_other(WT_FIX64);
          2: add_other(WT_LEN);
          default: add_other(WT_FIX32);
        endcase
      end
    endcase
  endfunction

  function automatic logic [63:0] len_over();
    return (64'd1 << LENGTH_BITS) + 64'($urandom_range(0, 1000));
  endfunction

  // Only one stream per run (the block stops after its end record), so the
  // way it ends is picked at random: clean, or one of the error kinds.
  function automatic void add_ending();
    case ($urandom_range(0, 6))
      0: stream_q.push_back(8'h80);                      // inside a top tag
      1: begin                                           // reserved wire type
        put_varint(stream_q, {61'd9, 3'($urandom_range(3, 4))});
        put_bytes(stream_q, 12);
      end
      2: begin                                           // overlong varint
        repeat (10) stream_q.push_back(8'hFF);
        put_bytes(stream_q, 12);
      end
      3: begin                                           // message too long
        put_varint(stream_q, {TOP_FUNCTION, WT_LEN});
        put_varint(stream_q, len_over());
        put_bytes(stream_q, 12);
      end
      4: begin                                           // message cut by end
        put_varint(stream_q, {TOP_SAMPLE, WT_LEN});
        put_varint(stream_q, 64'd6);
        put_bytes(stream_q, $urandom_range(0, 5));
      end
      5: stream_q.push_back(8'h2A);                      // stop before length
      default: ;                                         // after a whole field
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus
  initial begin
    int n_body;
    bytes_if.valid = 1'b0;
    bytes_if.data_byte = '0;
    bytes_if.final_byte = 1'b0;

    // directed: empty messages, extreme ids, each skip wire type
    stream_q.push_back(8'h2A); stream_q.push_back(8'h00);   // empty function
    stream_q.push_back(8'h22); stream_q.push_back(8'h00);   // empty location
    stream_q.push_back(8'h12); stream_q.push_back(8'h00);   // empty sample
    stream_q.push_back(8'h32); stream_q.push_back(8'h00);   // empty string
    add_string(3);
    add_other(WT_VARINT); add_other(WT_FIX64); add_other(WT_LEN); add_other(WT_FIX32);
    begin
      octet_t body[$];
      put_varint(body, {ITEM_ID, WT_VARINT}); put_varint(body, '1);
      put_varint(body, {FUNC_NAME, WT_VARINT}); put_varint(body, 64'h8000_0000_0000_0000);
      put_wrapped(stream_q, {TOP_FUNCTION, WT_LEN}, body, 0);
    end
    add_location(4);
    add_sample(6);

    n_body = STREAM_LEN;
    while (stream_q.size() < n_body) add_any();
    add_ending();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stream_q[i]) begin
      int g;
      if (i % 200 == 0) calm = ($urandom_range(0, 3) == 0);
      g = gap_len();
      if (g > 0) begin
        bytes_if.valid <= 1'b0;
        repeat (g) @(negedge clk);
      end
      bytes_if.valid <= 1'b1;
      bytes_if.data_byte <= stream_q[i];
      bytes_if.final_byte <= (i == stream_q.size() - 1);
      @(posedge clk);
      while (!bytes_if.ready) @(posedge clk);
      @(negedge clk);
    end
    // trailing bytes after the end record must be dropped
    repeat (4) begin
      bytes_if.valid <= 1'b1;
      bytes_if.data_byte <= 8'($urandom_range(0, 255));
      bytes_if.final_byte <= 1'($urandom_range(0, 1));
      @(posedge clk);
      while (!bytes_if.ready) @(posedge clk);
      @(negedge clk);
    end
    bytes_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  // record side back-pressure, changed at the falling edge
  initial begin
    int stall;
    stall = 0;
    recs_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        recs_if.ready <= 1'b0;
        stall--;
      end else begin
        recs_if.ready <= 1'b1;
        stall = gap_len();
      end
    end
  end

  // watchdog: ends the run when no transaction happens for too long
  always @(posedge clk) begin
    if (rst || (bytes_if.valid && bytes_if.ready) || (recs_if.valid && recs_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

endmodule
